@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge, skipped while reset is high.
`define CHK_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("port check failed");

// A property checked at every rising edge, including reset cycles.
`define CHK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) else $error("port check failed");

`endif

@@ rtl/rbs_pkg.sv @@
package rbs_pkg;

   // Coordinate format: signed fixed point.
   localparam int CW = 32;
   localparam int FB = 16;
   // Quotient bits kept after the overflow check.
   localparam int QW = CW + 1;
   // Numerator width: |bound - origin| scaled by 2^FB.
   localparam int NW = CW + 1 + FB;
   // Number of divider lanes: low and high bound for each of three axes.
   localparam int LANES = 6;
   // Clock edges from the accepting edge to the edge that takes the result.
   localparam int RSP_LATENCY = QW + 5;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [2:0] {
      CSR_BOX_X_LOW  = 3'd0,
      CSR_BOX_X_HIGH = 3'd1,
      CSR_BOX_Y_LOW  = 3'd2,
      CSR_BOX_Y_HIGH = 3'd3,
      CSR_BOX_Z_LOW  = 3'd4,
      CSR_BOX_Z_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type [2:0] origin;
      coord_type [2:0] dir;
      coord_type       t_min;
      coord_type       t_max;
   } ray_type;

   // Bounds, low at even and high at odd positions, x first.
   typedef coord_type [LANES-1:0] box_type;

   // State of one divider lane between two cells.
   typedef struct packed {
      logic [CW-1:0] rem;
      logic [QW-1:0] lq;
      logic [CW-1:0] dvs;
      logic          ovf;
   } lane_type;

   // Per-ray data that travels beside the divider lanes.
   typedef struct packed {
      coord_type        t_min;
      coord_type        t_max;
      logic [LANES-1:0] qneg;
      logic [2:0]       dneg;
      logic [2:0]       dzero;
      logic             zmiss;
   } side_type;

   localparam coord_type COORD_MAX = coord_type'({1'b0, {(CW-1){1'b1}}});
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(CW-1){1'b0}}});
   localparam logic [QW-1:0] MAG_MAX = QW'({1'b0, {(CW-1){1'b1}}});

endpackage

@@ rtl/rbs_div_cell.sv @@
module rbs_div_cell
   import rbs_pkg::*;
(
   input  logic     clock,
   input  lane_type d_in,
   output lane_type d_out
);

   logic [CW:0]   trial;
   logic [CW:0]   diff;
   logic          ge;
   lane_type      d_out_in;
   lane_type      d_out_ff;

   // One restoring division step: bring in the next numerator bit and subtract if it fits.
   always_comb begin
      trial = {d_in.rem, d_in.lq[QW-1]};
      diff  = trial - {1'b0, d_in.dvs};
      ge    = (trial >= {1'b0, d_in.dvs});
      d_out_in.rem = ge ? diff[CW-1:0] : trial[CW-1:0];
      d_out_in.lq  = {d_in.lq[QW-2:0], ge};
      d_out_in.dvs = d_in.dvs;
      d_out_in.ovf = d_in.ovf;
   end

   always_ff @(posedge clock) begin
      d_out_ff <= d_out_in;
   end

   assign d_out = d_out_ff;

endmodule

@@ rtl/rbs_prep.sv @@
module rbs_prep
   import rbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  ray_type                ray,
   input  box_type                box,
   output logic                   out_vld,
   output lane_type [LANES-1:0]   lanes,
   output side_type               side
);

   logic                  vld_ff;
   lane_type [LANES-1:0]  lanes_in;
   lane_type [LANES-1:0]  lanes_ff;
   side_type              side_in;
   side_type              side_ff;
   logic [CW:0]           diff   [LANES];
   logic [CW:0]           mag    [LANES];
   logic [NW-1:0]         num    [LANES];
   logic [CW+FB-1:0]      upper  [LANES];
   logic [CW+FB-1:0]      dvs_x  [LANES];
   logic [CW-1:0]         dmag   [3];
   logic [2:0]            outside;

   // Magnitudes, signs and the overflow check of each slab distance.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dmag[a] = ray.dir[a][CW-1] ? (~ray.dir[a] + 1'b1) : ray.dir[a];
         outside[a] = (ray.origin[a] < box[2*a]) || (ray.origin[a] > box[2*a+1]);
      end
      for (int l = 0; l < LANES; l++) begin
         diff[l]  = {box[l][CW-1], box[l]} - {ray.origin[l/2][CW-1], ray.origin[l/2]};
         mag[l]   = diff[l][CW] ? (~diff[l] + 1'b1) : diff[l];
         num[l]   = {mag[l], {FB{1'b0}}};
         upper[l] = {{CW{1'b0}}, num[l][NW-1:QW]};
         dvs_x[l] = {{FB{1'b0}}, dmag[l/2]};
         lanes_in[l].ovf = (upper[l] >= dvs_x[l]);
         lanes_in[l].rem = upper[l][CW-1:0];
         lanes_in[l].lq  = num[l][QW-1:0];
         lanes_in[l].dvs = dmag[l/2];
         side_in.qneg[l] = diff[l][CW] ^ ray.dir[l/2][CW-1];
      end
      for (int a = 0; a < 3; a++) begin
         side_in.dneg[a]  = ray.dir[a][CW-1];
         side_in.dzero[a] = (ray.dir[a] == '0);
      end
      side_in.zmiss = |(side_in.dzero & outside);
      side_in.t_min = ray.t_min;
      side_in.t_max = ray.t_max;
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      side_ff  <= side_in;
   end

   assign out_vld = vld_ff;
   assign lanes   = lanes_ff;
   assign side    = side_ff;

endmodule

@@ rtl/rbs_finish.sv @@
module rbs_finish
   import rbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  lane_type [LANES-1:0] lanes,
   input  side_type             side,
   output logic                 out_vld,
   output logic                 hit,
   output coord_type            t_enter,
   output coord_type            t_exit
);

   coord_type        q_sat [LANES];
   coord_type        near_in [3];
   coord_type        far_in  [3];
   coord_type        near_ff [3];
   coord_type        far_ff  [3];
   coord_type        tmin1_ff, tmax1_ff;
   logic             zmiss1_ff, zmiss2_ff, zmiss3_ff;
   coord_type        lo_a_ff, lo_b_ff, hi_a_ff, hi_b_ff;
   coord_type        lo_ff, hi_ff;
   logic [3:0]       vld_ff;
   logic             hit_in;
   logic             hit_ff;
   coord_type        enter_ff, exit_ff;

   // Saturate and sign each quotient, then order near and far per axis.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (side.qneg[l]) begin
            if (lanes[l].ovf || (lanes[l].lq > MAG_MAX + 1'b1)) begin
               q_sat[l] = COORD_MIN;
            end else begin
               q_sat[l] = coord_type'(~lanes[l].lq + 1'b1);
            end
         end else begin
            if (lanes[l].ovf || (lanes[l].lq > MAG_MAX)) begin
               q_sat[l] = COORD_MAX;
            end else begin
               q_sat[l] = coord_type'(lanes[l].lq);
            end
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (side.dzero[a]) begin
            near_in[a] = COORD_MIN;
            far_in[a]  = COORD_MAX;
         end else if (side.dneg[a]) begin
            near_in[a] = q_sat[2*a+1];
            far_in[a]  = q_sat[2*a];
         end else begin
            near_in[a] = q_sat[2*a];
            far_in[a]  = q_sat[2*a+1];
         end
      end
   end

   // Final test: no zero-direction miss and a non-empty clipped interval.
   assign hit_in = !zmiss3_ff && (lo_ff < hi_ff);

   // Valid flags of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   // Near and far registers, interval narrowing in two levels of max and min, then the output register.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         near_ff[a] <= near_in[a];
         far_ff[a]  <= far_in[a];
      end
      tmin1_ff  <= side.t_min;
      tmax1_ff  <= side.t_max;
      zmiss1_ff <= side.zmiss;

      lo_a_ff   <= (near_ff[0] > tmin1_ff) ? near_ff[0] : tmin1_ff;
      lo_b_ff   <= (near_ff[1] > near_ff[2]) ? near_ff[1] : near_ff[2];
      hi_a_ff   <= (far_ff[0] < tmax1_ff) ? far_ff[0] : tmax1_ff;
      hi_b_ff   <= (far_ff[1] < far_ff[2]) ? far_ff[1] : far_ff[2];
      zmiss2_ff <= zmiss1_ff;

      lo_ff     <= (lo_a_ff > lo_b_ff) ? lo_a_ff : lo_b_ff;
      hi_ff     <= (hi_a_ff < hi_b_ff) ? hi_a_ff : hi_b_ff;
      zmiss3_ff <= zmiss2_ff;

      hit_ff    <= hit_in;
      enter_ff  <= hit_in ? lo_ff : '0;
      exit_ff   <= hit_in ? hi_ff : '0;
   end

   assign out_vld = vld_ff[3];
   assign hit     = hit_ff;
   assign t_enter = enter_ff;
   assign t_exit  = exit_ff;

endmodule

@@ rtl/ray_box_slab_test.sv @@
// Ray versus axis-aligned box slab test.
// The box is six signed Q16.16 bounds written through the csr_ port: csr_we
// writes csr_wdata into register csr_index (x low, x high, y low, y high,
// z low, z high); other indexes are ignored. Write them only while idle.
// A ray transfer (origin, direction, t_min, t_max) happens at each rising edge
// with start high and busy low. busy is always low, so a ray may be sent
// every cycle and the block takes one ray per cycle, sustained.
// Each ray gives exactly one result: rsp_valid is high for one cycle, with
// rsp_hit, rsp_t_enter and rsp_t_exit (zero on a miss). Results leave in
// the order rays came in. The pipeline holds the six slab divisions, each
// a row of 33 divider cells that produce one quotient bit per cell, plus
// one setup stage and four stages of saturation, interval clipping and output.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// Reset clears all rays in flight and sets the box bounds to zero.
module ray_box_slab_test
   import rbs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  coord_type req_origin_x,
   input  coord_type req_origin_y,
   input  coord_type req_origin_z,
   input  coord_type req_dir_x,
   input  coord_type req_dir_y,
   input  coord_type req_dir_z,
   input  coord_type req_t_min,
   input  coord_type req_t_max,
   output logic      rsp_valid,
   output logic      rsp_hit,
   output coord_type rsp_t_enter,
   output coord_type rsp_t_exit,
   input  logic      csr_we,
   input  logic [2:0] csr_index,
   input  coord_type csr_wdata
);

   box_type               box_ff;
   ray_type               ray;
   logic                  prep_vld;
   lane_type [LANES-1:0]  prep_lanes;
   side_type              prep_side;
   lane_type [LANES-1:0]  chain [QW+1];
   side_type              side_ff [QW];
   logic [QW-1:0]         vld_ff;

   assign busy = 1'b0;

   // Box registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_X_LOW:  box_ff[0] <= csr_wdata;
            CSR_BOX_X_HIGH: box_ff[1] <= csr_wdata;
            CSR_BOX_Y_LOW:  box_ff[2] <= csr_wdata;
            CSR_BOX_Y_HIGH: box_ff[3] <= csr_wdata;
            CSR_BOX_Z_LOW:  box_ff[4] <= csr_wdata;
            CSR_BOX_Z_HIGH: box_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Gather the request ports.
   always_comb begin
      ray.origin[0] = req_origin_x;
      ray.origin[1] = req_origin_y;
      ray.origin[2] = req_origin_z;
      ray.dir[0]    = req_dir_x;
      ray.dir[1]    = req_dir_y;
      ray.dir[2]    = req_dir_z;
      ray.t_min     = req_t_min;
      ray.t_max     = req_t_max;
   end

   rbs_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start && !busy),
      .ray     (ray),
      .box     (box_ff),
      .out_vld (prep_vld),
      .lanes   (prep_lanes),
      .side    (prep_side)
   );

   assign chain[0] = prep_lanes;

   // Rows of divider cells, one quotient bit per cell and lane.
   for (genvar s = 0; s < QW; s++) begin : g_stage
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         rbs_div_cell u_cell (
            .clock (clock),
            .d_in  (chain[s][l]),
            .d_out (chain[s+1][l])
         );
      end
   end

   // Valid flags beside the cells.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QW-2:0], prep_vld};
      end
   end

   // Per-ray data beside the cells.
   always_ff @(posedge clock) begin
      side_ff[0] <= prep_side;
      for (int s = 1; s < QW; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   rbs_finish u_finish (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (vld_ff[QW-1]),
      .lanes   (chain[QW]),
      .side    (side_ff[QW-1]),
      .out_vld (rsp_valid),
      .hit     (rsp_hit),
      .t_enter (rsp_t_enter),
      .t_exit  (rsp_t_exit)
   );

endmodule

@@ rtl/rbs_checker.sv @@
`include "assert_macros.svh"

module rbs_checker
   import rbs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_hit,
   input coord_type  rsp_t_enter,
   input coord_type  rsp_t_exit
);

   // Every ray transfer gives a result after the fixed latency.
   `CHK_PROP(a_req_to_rsp, clock, reset, (start && !busy) |-> ##RSP_LATENCY rsp_valid)

   // No result appears without a ray transfer at the matching edge.
   `CHK_PROP(a_rsp_from_req, clock, reset, rsp_valid |-> $past(start && !busy, RSP_LATENCY))

   // A hit carries a non-empty interval, a miss carries zeros.
   `CHK_PROP(a_hit_interval, clock, reset, (rsp_valid && rsp_hit) |-> (rsp_t_enter < rsp_t_exit))
   `CHK_PROP(a_miss_zero, clock, reset, (rsp_valid && !rsp_hit) |-> (rsp_t_enter == '0 && rsp_t_exit == '0))

   // The block never holds a ray off.
   `CHK_ALWAYS(a_never_busy, clock, !busy)

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (.*);
